>>> rtl/core/svc_pkg.sv
// ============================================================================
// svc_pkg: shared types and constants of the spike vote classifier scorer
// Fixed field widths, register indexes, outcome codes and the state types of
// the front and back sequencers.
// ============================================================================
`default_nettype none

package svc_pkg;

  // Fixed widths of the ports and configuration registers.
  localparam int CLS_CFG_W   = 7;
  localparam int STEPS_W     = 16;
  localparam int LABEL_W     = 6;
  localparam int CLASS_OUT_W = 6;
  localparam int OUTCOME_W   = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // Neuron index bits retired per cycle by the modulo unit.
  localparam int DIGIT_W = 4;

  // Command queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CLASSES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEPS   = 2'd1;

  // Configuration reset values.
  localparam logic [CLS_CFG_W-1:0] CLASSES_RST = 7'd10;
  localparam logic [STEPS_W-1:0]   STEPS_RST   = 16'd20;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_CORRECT   = 2'd0,
    OUT_INCORRECT = 2'd1,
    OUT_NO_VOTES  = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_VOTE_WR,
    B_SCAN,
    B_SCAN_END,
    B_CLOSE
  } back_state_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/spike_vote_classifier_scorer.sv
// ============================================================================
// spike_vote_classifier_scorer: spike count vote readout with label scoring
// Spikes vote for class (neuron index mod classes in use); a window-closing
// step tick picks the winning class and scores it against the true label.
// ============================================================================
// Spike: the front takes no new item until the modulo unit, retiring 4 index
//   bits per cycle, has reduced the index and pushed the command.
// Non-closing tick: pushed straight from idle; the back end counts the step.
// Closing tick: the back end walks the vote store one class per cycle, then
//   passes through B_SCAN_END and B_CLOSE; out_valid rises from the result
//   register loaded in B_CLOSE once that register is free.
// Reset: vote and statistic stores read as zero through valid bits, with no
//   clearing pass; classes in use resets to 10 and steps per window to 20.
`default_nettype none

module spike_vote_classifier_scorer #(
  parameter int MAX_CLASSES        = 64,
  parameter int COUNT_WIDTH        = 32,
  parameter int NEURON_INDEX_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_mode,
  input  logic [NEURON_INDEX_WIDTH-1:0]     in_neuron_index,
  input  logic [svc_pkg::LABEL_W-1:0]       in_true_label,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [svc_pkg::CLASS_OUT_W-1:0]   out_predicted_class,
  output logic [COUNT_WIDTH-1:0]            out_winning_votes,
  output logic [svc_pkg::OUTCOME_W-1:0]     out_outcome,
  output logic [svc_pkg::LABEL_W-1:0]       out_label_echo,
  output logic [COUNT_WIDTH-1:0]            out_label_total,
  output logic [COUNT_WIDTH-1:0]            out_label_correct,
  output logic [COUNT_WIDTH-1:0]            out_label_incorrect,
  output logic [COUNT_WIDTH-1:0]            out_label_no_votes,
  // Configuration write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [svc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [svc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import svc_pkg::*;

  localparam int CLS_W = $clog2(MAX_CLASSES);

  logic [CLS_CFG_W-1:0] cfg_classes_r;
  logic [STEPS_W-1:0]   cfg_steps_r;
  logic [CLS_CFG_W-1:0] ncls;
  logic                 q_push, q_pop;
  logic [CLS_W:0]       q_wr_data, q_rd_data;
  fifo_stat_t           q_stat;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_classes_r <= CLASSES_RST;
      cfg_steps_r   <= STEPS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CLASSES: cfg_classes_r <= cfg_data[CLS_CFG_W-1:0];
        CFG_STEPS:   cfg_steps_r   <= cfg_data[STEPS_W-1:0];
        default: begin
          cfg_steps_r <= cfg_steps_r;
        end
      endcase
    end
  end

  // Effective class count: zero means one, and the store depth caps it.
  always_comb begin
    if (cfg_classes_r == '0) begin
      ncls = CLS_CFG_W'(1);
    end else if (32'(cfg_classes_r) > MAX_CLASSES) begin
      ncls = CLS_CFG_W'(MAX_CLASSES);
    end else begin
      ncls = cfg_classes_r;
    end
  end

  svc_front #(
    .MAX_CLASSES        (MAX_CLASSES),
    .NEURON_INDEX_WIDTH (NEURON_INDEX_WIDTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_neuron_index (in_neuron_index),
    .in_true_label   (in_true_label),
    .ncls            (ncls),
    .q_stat          (q_stat),
    .q_push          (q_push),
    .q_data          (q_wr_data)
  );

  svc_cmd_fifo #(
    .WIDTH (CLS_W + 1)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .stat    (q_stat)
  );

  svc_back #(
    .MAX_CLASSES (MAX_CLASSES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_stat              (q_stat),
    .q_data              (q_rd_data),
    .q_pop               (q_pop),
    .ncls                (ncls),
    .steps_cfg           (cfg_steps_r),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_predicted_class (out_predicted_class),
    .out_winning_votes   (out_winning_votes),
    .out_outcome         (out_outcome),
    .out_label_echo      (out_label_echo),
    .out_label_total     (out_label_total),
    .out_label_correct   (out_label_correct),
    .out_label_incorrect (out_label_incorrect),
    .out_label_no_votes  (out_label_no_votes)
  );

endmodule

`default_nettype wire

>>> rtl/core/svc_front.sv
// ============================================================================
// svc_front: item intake and classification
// Accepts spikes and step ticks. A spike's neuron index is reduced modulo the
// classes in use, a few bits per cycle; a tick's label is reduced modulo the
// class store depth. Both leave as commands for the back end.
// ============================================================================
`default_nettype none

module svc_front #(
  parameter int MAX_CLASSES        = 64,
  parameter int NEURON_INDEX_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_mode,
  input  logic [NEURON_INDEX_WIDTH-1:0]       in_neuron_index,
  input  logic [svc_pkg::LABEL_W-1:0]         in_true_label,
  input  logic [svc_pkg::CLS_CFG_W-1:0]       ncls,
  input  svc_pkg::fifo_stat_t                 q_stat,
  output logic                                q_push,
  output logic [$clog2(MAX_CLASSES):0]        q_data
);
  import svc_pkg::*;

  localparam int CLS_W = $clog2(MAX_CLASSES);
  localparam int NITER = (NEURON_INDEX_WIDTH + DIGIT_W - 1) / DIGIT_W;
  localparam int PAD_W = NITER * DIGIT_W;
  localparam int CNT_W = $clog2(NITER + 1);
  localparam int LBL_N = 2 ** LABEL_W;

  front_state_t           state_r, state_nxt;
  logic [PAD_W-1:0]       sh_r, sh_nxt;
  logic [CLS_CFG_W-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [CLS_CFG_W-1:0]   rem_step;
  logic [CLS_CFG_W:0]     trial;
  logic [CLS_CFG_W-1:0]   push_rem;
  logic [CLS_W+CLS_CFG_W-1:0] rem_ext;
  logic [CLS_W-1:0]       lbl_tbl [LBL_N];
  logic                   accept;

  // Label reduction table, fixed at elaboration.
  for (genvar g = 0; g < LBL_N; g++) begin : g_lbl
    assign lbl_tbl[g] = CLS_W'(g % MAX_CLASSES);
  end

  // One modulo step: retire DIGIT_W index bits into the running remainder.
  always_comb begin
    rem_step = rem_r;
    trial    = '0;
    for (int k = 0; k < DIGIT_W; k++) begin
      trial = {rem_step, sh_r[PAD_W-1-k]};
      if (trial >= {1'b0, ncls}) begin
        trial = trial - {1'b0, ncls};
      end
      rem_step = trial[CLS_CFG_W-1:0];
    end
  end

  assign rem_ext = {{CLS_W{1'b0}}, push_rem};

  // Intake sequencer.
  always_comb begin
    state_nxt = state_r;
    sh_nxt    = sh_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    in_stall  = (state_r != F_IDLE) || q_stat.full;
    accept    = in_valid && !in_stall;
    q_push    = 1'b0;
    push_rem  = rem_r;
    q_data    = {1'b1, lbl_tbl[in_true_label]};
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          if (in_mode) begin
            q_push = 1'b1;
          end else begin
            sh_nxt    = PAD_W'(in_neuron_index);
            rem_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = F_DIV;
          end
        end
      end
      F_DIV: begin
        sh_nxt   = sh_r << DIGIT_W;
        rem_nxt  = rem_step;
        cnt_nxt  = cnt_r + CNT_W'(1);
        push_rem = rem_step;
        q_data   = {1'b0, rem_ext[CLS_W-1:0]};
        if (cnt_r == CNT_W'(NITER - 1)) begin
          if (!q_stat.full) begin
            q_push    = 1'b1;
            state_nxt = F_IDLE;
          end else begin
            state_nxt = F_PUSH;
          end
        end
      end
      F_PUSH: begin
        q_data = {1'b0, rem_ext[CLS_W-1:0]};
        if (!q_stat.full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/core/svc_cmd_fifo.sv
// ============================================================================
// svc_cmd_fifo: command queue between front and back
// A short first-in first-out buffer so that intake and scoring stall apart.
// ============================================================================
`default_nettype none

module svc_cmd_fifo #(
  parameter int WIDTH = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [WIDTH-1:0]    wr_data,
  input  logic                pop,
  output logic [WIDTH-1:0]    rd_data,
  output svc_pkg::fifo_stat_t stat
);
  import svc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   cnt_r;
  logic             do_push, do_pop;

  assign stat.full  = (cnt_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_data    = mem[rd_ptr_r];

  // Pointer and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + (PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - (PTR_W+1)'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/svc_back.sv
// ============================================================================
// svc_back: vote store, window closing and label scoring
// Executes queued commands: counts votes, tracks window steps, walks the vote
// store for the winner, updates the label statistics and registers a result.
// ============================================================================
`default_nettype none

module svc_back #(
  parameter int MAX_CLASSES = 64,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  svc_pkg::fifo_stat_t               q_stat,
  input  logic [$clog2(MAX_CLASSES):0]      q_data,
  output logic                              q_pop,
  input  logic [svc_pkg::CLS_CFG_W-1:0]     ncls,
  input  logic [svc_pkg::STEPS_W-1:0]       steps_cfg,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [svc_pkg::CLASS_OUT_W-1:0]   out_predicted_class,
  output logic [COUNT_WIDTH-1:0]            out_winning_votes,
  output logic [svc_pkg::OUTCOME_W-1:0]     out_outcome,
  output logic [svc_pkg::LABEL_W-1:0]       out_label_echo,
  output logic [COUNT_WIDTH-1:0]            out_label_total,
  output logic [COUNT_WIDTH-1:0]            out_label_correct,
  output logic [COUNT_WIDTH-1:0]            out_label_incorrect,
  output logic [COUNT_WIDTH-1:0]            out_label_no_votes
);
  import svc_pkg::*;

  localparam int CLS_W = $clog2(MAX_CLASSES);
  localparam int CMP_W = ((CLS_W > CLS_CFG_W) ? CLS_W : CLS_CFG_W) + 1;

  // Vote store with per-entry valid bits.
  logic [COUNT_WIDTH-1:0] vote_mem [MAX_CLASSES];
  logic [MAX_CLASSES-1:0] vote_vld_r;
  logic [COUNT_WIDTH-1:0] vote_q_r;
  logic                   vote_qv_r;
  logic [CLS_W-1:0]       vote_raddr;
  logic                   vote_we;
  logic [COUNT_WIDTH-1:0] vote_val, vote_wdata;

  // Statistic stores, one row per label, sharing a row valid bit.
  logic [COUNT_WIDTH-1:0] tot_mem [MAX_CLASSES];
  logic [COUNT_WIDTH-1:0] cor_mem [MAX_CLASSES];
  logic [COUNT_WIDTH-1:0] inc_mem [MAX_CLASSES];
  logic [COUNT_WIDTH-1:0] nov_mem [MAX_CLASSES];
  logic [MAX_CLASSES-1:0] stat_vld_r;
  logic [COUNT_WIDTH-1:0] tot_q_r, cor_q_r, inc_q_r, nov_q_r;
  logic                   stat_qv_r;
  logic [COUNT_WIDTH-1:0] tot_old, cor_old, inc_old, nov_old;
  logic [COUNT_WIDTH-1:0] tot_new, cor_new, inc_new, nov_new;

  // Sequencer state.
  back_state_t            state_r, state_nxt;
  logic [CLS_W-1:0]       idx_r, idx_nxt;
  logic [CLS_W-1:0]       cls_r, cls_nxt;
  logic [CLS_W-1:0]       label_r, label_nxt;
  logic [STEPS_W-1:0]     step_r, step_nxt;
  logic                   cmp_vld_r, cmp_vld_nxt;
  logic [CLS_W-1:0]       cmp_idx_r;
  logic [CLS_W-1:0]       best_r;
  logic [COUNT_WIDTH-1:0] best_votes_r;
  logic                   scan_start, close_load, scan_last, out_free;
  logic [STEPS_W-1:0]     steps_eff, step_inc;
  logic [CLS_W-1:0]       q_idx;
  logic                   q_tick;
  outcome_t               outcome_c;

  // Output register.
  logic                   out_valid_r;
  logic [CLASS_OUT_W-1:0] out_predicted_class_r;
  logic [COUNT_WIDTH-1:0] out_winning_votes_r;
  outcome_t               out_outcome_r;
  logic [LABEL_W-1:0]     out_label_echo_r;
  logic [COUNT_WIDTH-1:0] out_label_total_r, out_label_correct_r;
  logic [COUNT_WIDTH-1:0] out_label_incorrect_r, out_label_no_votes_r;
  logic [CLS_W+CLASS_OUT_W-1:0] best_ext, label_ext;

  assign q_idx     = q_data[CLS_W-1:0];
  assign q_tick    = q_data[CLS_W];
  assign steps_eff = (steps_cfg == '0) ? STEPS_W'(1) : steps_cfg;
  assign step_inc  = step_r + STEPS_W'(1);
  assign scan_last = (CMP_W'(idx_r) + CMP_W'(1)) == CMP_W'(ncls);
  assign out_free  = !out_valid_r || !out_stall;

  // An entry that was never written since the last clear reads as zero.
  assign vote_val   = vote_qv_r ? vote_q_r : '0;
  assign vote_wdata = (vote_val == '1) ? vote_val : vote_val + COUNT_WIDTH'(1);

  // Statistic update for the closing label.
  assign tot_old = stat_qv_r ? tot_q_r : '0;
  assign cor_old = stat_qv_r ? cor_q_r : '0;
  assign inc_old = stat_qv_r ? inc_q_r : '0;
  assign nov_old = stat_qv_r ? nov_q_r : '0;

  always_comb begin
    if (best_votes_r == '0) begin
      outcome_c = OUT_NO_VOTES;
    end else if (best_r != label_r) begin
      outcome_c = OUT_INCORRECT;
    end else begin
      outcome_c = OUT_CORRECT;
    end
    tot_new = (tot_old == '1) ? tot_old : tot_old + COUNT_WIDTH'(1);
    cor_new = cor_old;
    inc_new = inc_old;
    nov_new = nov_old;
    unique case (outcome_c)
      OUT_CORRECT: begin
        cor_new = (cor_old == '1) ? cor_old : cor_old + COUNT_WIDTH'(1);
      end
      OUT_INCORRECT: begin
        inc_new = (inc_old == '1) ? inc_old : inc_old + COUNT_WIDTH'(1);
      end
      OUT_NO_VOTES: begin
        nov_new = (nov_old == '1) ? nov_old : nov_old + COUNT_WIDTH'(1);
      end
      default: begin
        nov_new = nov_old;
      end
    endcase
  end

  // Command sequencer: next state and control.
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    cls_nxt     = cls_r;
    label_nxt   = label_r;
    step_nxt    = step_r;
    q_pop       = 1'b0;
    vote_raddr  = q_idx;
    vote_we     = 1'b0;
    cmp_vld_nxt = 1'b0;
    scan_start  = 1'b0;
    close_load  = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          q_pop = 1'b1;
          if (!q_tick) begin
            cls_nxt   = q_idx;
            state_nxt = B_VOTE_WR;
          end else if (step_inc >= steps_eff) begin
            step_nxt   = '0;
            label_nxt  = q_idx;
            idx_nxt    = '0;
            scan_start = 1'b1;
            state_nxt  = B_SCAN;
          end else begin
            step_nxt = step_inc;
          end
        end
      end
      B_VOTE_WR: begin
        vote_we   = 1'b1;
        state_nxt = B_IDLE;
      end
      B_SCAN: begin
        vote_raddr  = idx_r;
        cmp_vld_nxt = 1'b1;
        if (scan_last) begin
          state_nxt = B_SCAN_END;
        end else begin
          idx_nxt = idx_r + CLS_W'(1);
        end
      end
      B_SCAN_END: begin
        state_nxt = B_CLOSE;
      end
      B_CLOSE: begin
        if (out_free) begin
          close_load = 1'b1;
          state_nxt  = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  // Control registers and valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      step_r      <= '0;
      cmp_vld_r   <= 1'b0;
      vote_vld_r  <= '0;
      stat_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      step_r    <= step_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      if (close_load) begin
        vote_vld_r          <= '0;
        stat_vld_r[label_r] <= 1'b1;
      end else if (vote_we) begin
        vote_vld_r[cls_r] <= 1'b1;
      end
      if (close_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers and the running maximum of the vote walk.
  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    cls_r     <= cls_nxt;
    label_r   <= label_nxt;
    cmp_idx_r <= idx_r;
    if (scan_start) begin
      best_r       <= '0;
      best_votes_r <= '0;
    end else if (cmp_vld_r && (vote_val > best_votes_r)) begin
      best_r       <= cmp_idx_r;
      best_votes_r <= vote_val;
    end
  end

  // Memories: registered reads, single write port each.
  always_ff @(posedge clk) begin
    vote_q_r  <= vote_mem[vote_raddr];
    vote_qv_r <= vote_vld_r[vote_raddr];
    if (vote_we) begin
      vote_mem[cls_r] <= vote_wdata;
    end
    tot_q_r   <= tot_mem[label_r];
    cor_q_r   <= cor_mem[label_r];
    inc_q_r   <= inc_mem[label_r];
    nov_q_r   <= nov_mem[label_r];
    stat_qv_r <= stat_vld_r[label_r];
    if (close_load) begin
      tot_mem[label_r] <= tot_new;
      cor_mem[label_r] <= cor_new;
      inc_mem[label_r] <= inc_new;
      nov_mem[label_r] <= nov_new;
    end
  end

  // Result payload.
  assign best_ext  = {{CLASS_OUT_W{1'b0}}, best_r};
  assign label_ext = {{CLASS_OUT_W{1'b0}}, label_r};

  always_ff @(posedge clk) begin
    if (close_load) begin
      out_predicted_class_r <= best_ext[CLASS_OUT_W-1:0];
      out_winning_votes_r   <= best_votes_r;
      out_outcome_r         <= outcome_c;
      out_label_echo_r      <= label_ext[LABEL_W-1:0];
      out_label_total_r     <= tot_new;
      out_label_correct_r   <= cor_new;
      out_label_incorrect_r <= inc_new;
      out_label_no_votes_r  <= nov_new;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_predicted_class = out_predicted_class_r;
  assign out_winning_votes   = out_winning_votes_r;
  assign out_outcome         = out_outcome_r;
  assign out_label_echo      = out_label_echo_r;
  assign out_label_total     = out_label_total_r;
  assign out_label_correct   = out_label_correct_r;
  assign out_label_incorrect = out_label_incorrect_r;
  assign out_label_no_votes  = out_label_no_votes_r;

  // The vote walk never addresses a class outside those in use.
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_SCAN) |-> (CMP_W'(idx_r) < CMP_W'(ncls)))
    else $error("vote walk index beyond classes in use");

  // Closing a window empties the vote store.
  a_vote_clear: assert property (@(posedge clk) disable iff (!rst_n)
    close_load |=> (vote_vld_r == '0))
    else $error("votes survive a window close");

  // A no-vote outcome goes with zero winning votes and only then.
  a_no_votes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_outcome_r == OUT_NO_VOTES) == (out_winning_votes_r == '0)))
    else $error("no-vote outcome disagrees with winning votes");

  // A correct outcome names the label as the winner.
  a_correct: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_outcome_r == OUT_CORRECT)) |->
      (out_predicted_class_r == out_label_echo_r))
    else $error("correct outcome with a different predicted class");

endmodule

`default_nettype wire
